// ----- hdl/sbbc_pkg.sv -----
// Shared constants, codes and helpers for the swept box collision block.
package sbbc_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int MAX_REFINE_STEPS_DEF = 16;
    localparam int HALF_BITS            = 21;
    localparam int OFS_BITS             = 22;
    localparam int SUM_BITS             = 22;
    localparam int LEN_BITS             = 42;
    localparam int MIN_BITS             = 16;
    localparam int OV_BITS              = 36;
    localparam logic [MIN_BITS-1:0] MIN_HALF_RESET = 16'd1;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_START_HIT,
        KIND_WALK
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVN,
        ST_DIVX,
        ST_DIVY,
        ST_COARSE,
        ST_END,
        ST_REFINE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_OUT
    } state_t;

    // Inclusive overlap along one axis: |d| <= sum of half extents.
    function automatic logic ov_axis(input logic signed [OV_BITS-1:0] d,
                                     input logic [SUM_BITS-1:0] sum);
        logic signed [OV_BITS-1:0] se;
        se = OV_BITS'(sum);
        return (d <= se) && (d >= -se);
    endfunction

endpackage

// ----- hdl/sbbc_fifo.sv -----
// Two-entry show-ahead queue between the front and back parts.
module sbbc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((pop && !empty) ? 1 : 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
        end
        else
        begin
            assert (count_reg != 2'd3)
            else $error("queue count out of range");
        end
    end

endmodule

// ----- hdl/sbbc_div.sv -----
// Iterative restoring unsigned divider, one quotient bit per cycle.
module sbbc_div #(
    parameter int W = 22
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]    rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  div_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [W:0]    shifted;
    logic [W+1:0]  trial;
    logic          ge;

    assign shifted  = {rem_reg[W-1:0], quo_reg[W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, div_reg};
    assign ge       = ~trial[W+1];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? trial[W:0] : shifted;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                cnt_reg  <= CW'(W);
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= (cnt_reg == CW'(1));
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

endmodule

// ----- hdl/sbbc_front.sv -----
// Front part: clamps extents, finds the step floor and classifies each request.
module sbbc_front #(
    parameter int COORD_BITS = sbbc_pkg::COORD_BITS_DEF
) (
    input  logic                                     min_half_size,
    input  logic [sbbc_pkg::MIN_BITS-1:0]            min_half,
    input  logic signed [COORD_BITS-1:0]             mover_x,
    input  logic signed [COORD_BITS-1:0]             mover_y,
    input  logic [sbbc_pkg::HALF_BITS-1:0]           mover_half_w,
    input  logic [sbbc_pkg::HALF_BITS-1:0]           mover_half_h,
    input  logic signed [COORD_BITS-1:0]             obstacle_x,
    input  logic signed [COORD_BITS-1:0]             obstacle_y,
    input  logic [sbbc_pkg::HALF_BITS-1:0]           obstacle_half_w,
    input  logic [sbbc_pkg::HALF_BITS-1:0]           obstacle_half_h,
    input  logic signed [sbbc_pkg::OFS_BITS-1:0]     offset_x,
    input  logic signed [sbbc_pkg::OFS_BITS-1:0]     offset_y,
    output logic [4*COORD_BITS+4*sbbc_pkg::OFS_BITS+sbbc_pkg::HALF_BITS+1:0] entry
);

    localparam int HB = sbbc_pkg::HALF_BITS;

    logic [HB-1:0] mn, hw, hh, bhw, bhh, m1, m2, m3, s;
    logic [sbbc_pkg::SUM_BITS-1:0] sum_w, sum_h;
    logic signed [COORD_BITS:0] dfx, dfy;
    logic start_hit;
    sbbc_pkg::kind_t kind;

    assign mn  = HB'(min_half);
    assign hw  = (mover_half_w < mn) ? mn : mover_half_w;
    assign hh  = (mover_half_h < mn) ? mn : mover_half_h;
    assign bhw = (obstacle_half_w < mn) ? mn : obstacle_half_w;
    assign bhh = (obstacle_half_h < mn) ? mn : obstacle_half_h;

    assign m1 = (hw < bhw) ? hw : bhw;
    assign m2 = (hh < bhh) ? hh : bhh;
    assign m3 = (m1 < m2) ? m1 : m2;
    assign s  = (m3 == '0) ? HB'(1) : m3;

    assign sum_w = {1'b0, hw} + {1'b0, bhw};
    assign sum_h = {1'b0, hh} + {1'b0, bhh};

    assign dfx = (COORD_BITS+1)'(mover_x) - (COORD_BITS+1)'(obstacle_x);
    assign dfy = (COORD_BITS+1)'(mover_y) - (COORD_BITS+1)'(obstacle_y);
    assign start_hit = sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(dfx), sum_w)
                    && sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(dfy), sum_h);

    always_comb
    begin
        priority if (offset_x == '0 && offset_y == '0 || !min_half_size && 1'b0)
        begin
            kind = sbbc_pkg::KIND_ZERO;
        end
        else if (start_hit)
        begin
            kind = sbbc_pkg::KIND_START_HIT;
        end
        else
        begin
            kind = sbbc_pkg::KIND_WALK;
        end
    end

    assign entry = {obstacle_y, obstacle_x, mover_y, mover_x, sum_h, sum_w,
                    offset_y, offset_x, s, kind};

endmodule

// ----- hdl/sbbc_back.sv -----
// Back part: divides out the step, walks the path, refines and squares the move.
module sbbc_back #(
    parameter int COORD_BITS       = sbbc_pkg::COORD_BITS_DEF,
    parameter int MAX_REFINE_STEPS = sbbc_pkg::MAX_REFINE_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    input  logic [4*COORD_BITS+4*sbbc_pkg::OFS_BITS+sbbc_pkg::HALF_BITS+1:0] head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 collided,
    output logic [COORD_BITS-1:0]                stop_x,
    output logic [COORD_BITS-1:0]                stop_y,
    output logic [sbbc_pkg::OFS_BITS-1:0]        moved_x,
    output logic [sbbc_pkg::OFS_BITS-1:0]        moved_y,
    output logic [sbbc_pkg::LEN_BITS-1:0]        moved_length_sq
);

    localparam int OB = sbbc_pkg::OFS_BITS;
    localparam int PW = COORD_BITS + 2;
    localparam int RW = (MAX_REFINE_STEPS > 1) ? $clog2(MAX_REFINE_STEPS) : 1;

    // queue head fields
    logic signed [COORD_BITS-1:0] h_px, h_py, h_bx, h_by;
    logic [sbbc_pkg::SUM_BITS-1:0] h_sw, h_sh;
    logic signed [OB-1:0] h_ox, h_oy;
    logic [sbbc_pkg::HALF_BITS-1:0] h_s;
    logic [1:0] h_kind;

    assign {h_by, h_bx, h_py, h_px, h_sh, h_sw, h_oy, h_ox, h_s, h_kind} = head;

    sbbc_pkg::state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] px_reg, py_reg, bx_reg, by_reg;
    logic [sbbc_pkg::SUM_BITS-1:0] sw_reg, sh_reg;
    logic signed [OB-1:0] ox_reg, oy_reg, dx_reg, dy_reg;
    // refine can carry the box past the offset range, so keep the full travel
    logic signed [PW:0] lx_reg, ly_reg;
    logic [OB-1:0] n_reg, qx_reg, cnt_reg;
    logic signed [PW-1:0] cx_reg, cy_reg, fx_reg, fy_reg;
    logic [RW-1:0] rcnt_reg;
    logic signed [2*PW+1:0] sqx_reg, sqy_reg;
    logic out_valid_reg, collided_reg;
    logic [COORD_BITS-1:0] stop_x_reg, stop_y_reg;
    logic [OB-1:0] moved_x_reg, moved_y_reg;
    logic [sbbc_pkg::LEN_BITS-1:0] len_reg;

    // divider control
    logic div_start, div_done;
    logic [OB-1:0] div_dvd, div_dvs, div_q, n_now;
    logic [OB-1:0] abs_hx, abs_hy, abs_ox, abs_oy;
    logic signed [OB-1:0] q_signed_y;

    // walk datapath
    logic signed [PW-1:0] ex, ey, tx, ty;
    logic hit_c, hit_e, hit_t;
    logic signed [OB-1:0] hdx, hdy;
    logic ref_done;
    logic signed [PW:0] mvx, mvy;

    assign abs_hx = h_ox[OB-1] ? OB'(-h_ox) : OB'(h_ox);
    assign abs_hy = h_oy[OB-1] ? OB'(-h_oy) : OB'(h_oy);
    assign abs_ox = ox_reg[OB-1] ? OB'(-ox_reg) : OB'(ox_reg);
    assign abs_oy = oy_reg[OB-1] ? OB'(-oy_reg) : OB'(oy_reg);
    assign n_now  = (div_q == '0) ? OB'(1) : div_q;
    assign q_signed_y = oy_reg[OB-1] ? -$signed(div_q) : $signed(div_q);

    assign ex = PW'(px_reg) + PW'(ox_reg);
    assign ey = PW'(py_reg) + PW'(oy_reg);
    assign tx = fx_reg + PW'(dx_reg);
    assign ty = fy_reg + PW'(dy_reg);

    assign hit_c = sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(cx_reg - PW'(bx_reg)), sw_reg)
                && sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(cy_reg - PW'(by_reg)), sh_reg);
    assign hit_e = sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(ex - PW'(bx_reg)), sw_reg)
                && sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(ey - PW'(by_reg)), sh_reg);
    assign hit_t = sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(tx - PW'(bx_reg)), sw_reg)
                && sbbc_pkg::ov_axis(sbbc_pkg::OV_BITS'(ty - PW'(by_reg)), sh_reg);

    // step after this refine round
    assign hdx = hit_t ? (dx_reg >>> 1) : dx_reg;
    assign hdy = hit_t ? (dy_reg >>> 1) : dy_reg;
    assign ref_done = (hdx == '0 && hdy == '0) || (rcnt_reg == RW'(MAX_REFINE_STEPS - 1));
    assign mvx = (hit_t ? (PW+1)'(fx_reg) : (PW+1)'(tx)) - (PW+1)'(px_reg);
    assign mvy = (hit_t ? (PW+1)'(fy_reg) : (PW+1)'(ty)) - (PW+1)'(py_reg);

    sbbc_div #(.W(OB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbbc_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = (h_kind == sbbc_pkg::KIND_WALK) ? sbbc_pkg::ST_DIVN
                                                               : sbbc_pkg::ST_SQX;
                end
            end
            sbbc_pkg::ST_DIVN:   if (div_done) state_next = sbbc_pkg::ST_DIVX;
            sbbc_pkg::ST_DIVX:   if (div_done) state_next = sbbc_pkg::ST_DIVY;
            sbbc_pkg::ST_DIVY:   if (div_done) state_next = sbbc_pkg::ST_COARSE;
            sbbc_pkg::ST_COARSE:
            begin
                if (hit_c)
                begin
                    state_next = sbbc_pkg::ST_REFINE;
                end
                else if (cnt_reg + OB'(1) == n_reg)
                begin
                    state_next = sbbc_pkg::ST_END;
                end
            end
            sbbc_pkg::ST_END:
                state_next = hit_e ? sbbc_pkg::ST_REFINE : sbbc_pkg::ST_SQX;
            sbbc_pkg::ST_REFINE: if (ref_done) state_next = sbbc_pkg::ST_SQX;
            sbbc_pkg::ST_SQX:    state_next = sbbc_pkg::ST_SQY;
            sbbc_pkg::ST_SQY:    state_next = sbbc_pkg::ST_SUM;
            sbbc_pkg::ST_SUM:    state_next = sbbc_pkg::ST_OUT;
            sbbc_pkg::ST_OUT:    if (out_ready) state_next = sbbc_pkg::ST_IDLE;
            default:             state_next = sbbc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        div_dvd   = abs_ox;
        div_dvs   = n_reg;
        unique case (state_reg)
            sbbc_pkg::ST_IDLE:
            begin
                pop       = !empty;
                div_start = !empty && (h_kind == sbbc_pkg::KIND_WALK);
                div_dvd   = (abs_hx > abs_hy) ? abs_hx : abs_hy;
                div_dvs   = OB'(h_s);
            end
            sbbc_pkg::ST_DIVN:
            begin
                div_start = div_done;
                div_dvd   = abs_ox;
                div_dvs   = n_now;
            end
            sbbc_pkg::ST_DIVX:
            begin
                div_start = div_done;
                div_dvd   = abs_oy;
                div_dvs   = n_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sbbc_pkg::ST_IDLE:
            begin
                px_reg <= h_px;
                py_reg <= h_py;
                bx_reg <= h_bx;
                by_reg <= h_by;
                sw_reg <= h_sw;
                sh_reg <= h_sh;
                ox_reg <= h_ox;
                oy_reg <= h_oy;
                lx_reg <= (PW+1)'(h_ox);
                ly_reg <= (PW+1)'(h_oy);
                collided_reg <= (h_kind == sbbc_pkg::KIND_START_HIT);
                stop_x_reg   <= h_px;
                stop_y_reg   <= h_py;
                moved_x_reg  <= '0;
                moved_y_reg  <= '0;
            end
            sbbc_pkg::ST_DIVN:
            begin
                if (div_done)
                begin
                    n_reg <= n_now;
                end
            end
            sbbc_pkg::ST_DIVX:
            begin
                if (div_done)
                begin
                    qx_reg <= div_q;
                end
            end
            sbbc_pkg::ST_DIVY:
            begin
                dx_reg  <= ox_reg[OB-1] ? -$signed(qx_reg) : $signed(qx_reg);
                dy_reg  <= q_signed_y;
                cx_reg  <= PW'(px_reg);
                cy_reg  <= PW'(py_reg);
                fx_reg  <= PW'(px_reg);
                fy_reg  <= PW'(py_reg);
                cnt_reg <= '0;
            end
            sbbc_pkg::ST_COARSE:
            begin
                rcnt_reg <= '0;
                if (hit_c)
                begin
                    dx_reg <= dx_reg >>> 1;
                    dy_reg <= dy_reg >>> 1;
                end
                else
                begin
                    fx_reg  <= cx_reg;
                    fy_reg  <= cy_reg;
                    cx_reg  <= cx_reg + PW'(dx_reg);
                    cy_reg  <= cy_reg + PW'(dy_reg);
                    cnt_reg <= cnt_reg + OB'(1);
                end
            end
            sbbc_pkg::ST_END:
            begin
                rcnt_reg <= '0;
                if (hit_e)
                begin
                    dx_reg <= dx_reg >>> 1;
                    dy_reg <= dy_reg >>> 1;
                end
                else
                begin
                    collided_reg <= 1'b0;
                    stop_x_reg   <= ex[COORD_BITS-1:0];
                    stop_y_reg   <= ey[COORD_BITS-1:0];
                    moved_x_reg  <= ox_reg;
                    moved_y_reg  <= oy_reg;
                end
            end
            sbbc_pkg::ST_REFINE:
            begin
                dx_reg   <= hdx;
                dy_reg   <= hdy;
                rcnt_reg <= rcnt_reg + RW'(1);
                if (!hit_t)
                begin
                    fx_reg <= tx;
                    fy_reg <= ty;
                end
                collided_reg <= 1'b1;
                stop_x_reg   <= hit_t ? fx_reg[COORD_BITS-1:0] : tx[COORD_BITS-1:0];
                stop_y_reg   <= hit_t ? fy_reg[COORD_BITS-1:0] : ty[COORD_BITS-1:0];
                moved_x_reg  <= mvx[OB-1:0];
                moved_y_reg  <= mvy[OB-1:0];
                lx_reg       <= mvx;
                ly_reg       <= mvy;
            end
            sbbc_pkg::ST_SQX: sqx_reg <= lx_reg * lx_reg;
            sbbc_pkg::ST_SQY: sqy_reg <= ly_reg * ly_reg;
            sbbc_pkg::ST_SUM:
            begin
                len_reg <= sbbc_pkg::LEN_BITS'(sqx_reg + sqy_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbbc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sbbc_pkg::ST_SUM)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == sbbc_pkg::ST_OUT && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign collided        = collided_reg;
    assign stop_x          = stop_x_reg;
    assign stop_y          = stop_y_reg;
    assign moved_x         = moved_x_reg;
    assign moved_y         = moved_y_reg;
    assign moved_length_sq = len_reg;

    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == (state_reg == sbbc_pkg::ST_OUT))
        else $error("result valid outside output state");

    a_coarse_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbbc_pkg::ST_COARSE) |-> (cnt_reg < n_reg))
        else $error("coarse walk ran past step count");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == sbbc_pkg::ST_IDLE && !empty))
        else $error("queue popped while busy");

    a_refine_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbbc_pkg::ST_REFINE && ref_done) |=> (state_reg == sbbc_pkg::ST_SQX))
        else $error("refine did not finish");

endmodule

// ----- hdl/swept_box_box_collision_top.sv -----
// Top level: configuration register, stream packing, front, queue and back parts.
// Each request is popped from the queue; zero offset or overlap at start goes straight
// to squaring. Otherwise 3 divides, up to n coarse steps (n = max|offset| / step),
// one endpoint test, up to MAX_REFINE_STEPS refine rounds, then squaring and sum to
// result valid. One request in the back part at a time; next one starts after the
// result handshake. rst_n clears control state and sets min_half to 1.
module swept_box_box_collision_top #(
    parameter int COORD_BITS       = sbbc_pkg::COORD_BITS_DEF,
    parameter int MAX_REFINE_STEPS = sbbc_pkg::MAX_REFINE_STEPS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [sbbc_pkg::MIN_BITS-1:0] cfg_data,
    input  logic s_tvalid,
    output logic s_tready,
    // mover_x, mover_y, mover_half_w, mover_half_h, obstacle_x, obstacle_y,
    // obstacle_half_w, obstacle_half_h, offset_x, offset_y
    input  logic [((4*COORD_BITS+128+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // stop_x, stop_y, moved_x, moved_y, moved_length_sq
    output logic [((2*COORD_BITS+86+7)/8)*8-1:0] m_tdata,
    // collided
    output logic m_tuser
);

    localparam int C   = COORD_BITS;
    localparam int HB  = sbbc_pkg::HALF_BITS;
    localparam int OB  = sbbc_pkg::OFS_BITS;
    localparam int EW  = 4*C + 4*OB + HB + 2;
    localparam int OW  = ((2*C+86+7)/8)*8;

    logic [sbbc_pkg::MIN_BITS-1:0] min_half_reg;
    logic [EW-1:0] entry, head;
    logic full, empty, pop;
    logic collided;
    logic [C-1:0] stop_x, stop_y;
    logic [OB-1:0] moved_x, moved_y;
    logic [sbbc_pkg::LEN_BITS-1:0] moved_length_sq;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_half_reg <= sbbc_pkg::MIN_HALF_RESET;
        end
        else if (cfg_valid)
        begin
            min_half_reg <= cfg_data;
        end
    end

    sbbc_front #(.COORD_BITS(C)) u_front (
        .min_half_size   (1'b1),
        .min_half        (min_half_reg),
        .mover_x         (s_tdata[C-1:0]),
        .mover_y         (s_tdata[2*C-1:C]),
        .mover_half_w    (s_tdata[2*C+HB-1:2*C]),
        .mover_half_h    (s_tdata[2*C+2*HB-1:2*C+HB]),
        .obstacle_x      (s_tdata[3*C+2*HB-1:2*C+2*HB]),
        .obstacle_y      (s_tdata[4*C+2*HB-1:3*C+2*HB]),
        .obstacle_half_w (s_tdata[4*C+3*HB-1:4*C+2*HB]),
        .obstacle_half_h (s_tdata[4*C+4*HB-1:4*C+3*HB]),
        .offset_x        (s_tdata[4*C+4*HB+OB-1:4*C+4*HB]),
        .offset_y        (s_tdata[4*C+4*HB+2*OB-1:4*C+4*HB+OB]),
        .entry           (entry)
    );

    sbbc_fifo #(.WIDTH(EW)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s_tvalid),
        .wdata (entry),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (head)
    );

    sbbc_back #(
        .COORD_BITS       (C),
        .MAX_REFINE_STEPS (MAX_REFINE_STEPS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (empty),
        .head            (head),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .collided        (collided),
        .stop_x          (stop_x),
        .stop_y          (stop_y),
        .moved_x         (moved_x),
        .moved_y         (moved_y),
        .moved_length_sq (moved_length_sq)
    );

    assign m_tuser = collided;
    assign m_tdata = OW'({moved_length_sq, moved_y, moved_x, stop_y, stop_x});

endmodule
